/* rtl/core/gmhp_pkg.sv */
package gmhp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_FIXED   = 3'd1,
    PH_XLEN    = 3'd2,
    PH_EXTRA   = 3'd3,
    PH_NAME    = 3'd4,
    PH_COMMENT = 3'd5,
    PH_HCRC    = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_BAD_METH  = 3'd2,
    ST_RSVD_FLG  = 3'd3,
    ST_BAD_OS    = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_e;

  localparam logic [7:0] MAGIC0         = 8'h1f;
  localparam logic [7:0] MAGIC1         = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'h08;
  localparam logic [7:0] FL_RESERVED    = 8'he0;
  localparam logic [7:0] OS_LAST_KNOWN  = 8'd13;
  localparam logic [7:0] OS_UNKNOWN     = 8'd255;

  localparam logic [4:0] FL_HCRC    = 5'h02;
  localparam logic [4:0] FL_EXTRA   = 5'h04;
  localparam logic [4:0] FL_NAME    = 5'h08;
  localparam logic [4:0] FL_COMMENT = 5'h10;

  // Offsets inside the fixed ten-byte header
  localparam logic [3:0] IDX_MAGIC0 = 4'd0;
  localparam logic [3:0] IDX_MAGIC1 = 4'd1;
  localparam logic [3:0] IDX_METHOD = 4'd2;
  localparam logic [3:0] IDX_FLAGS  = 4'd3;
  localparam logic [3:0] IDX_MTIME0 = 4'd4;
  localparam logic [3:0] IDX_MTIME3 = 4'd7;
  localparam logic [3:0] IDX_OS     = 4'd9;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  field_index;
    logic [4:0]  flags;
    logic [15:0] skip;
    logic [31:0] stamp;
    logic [7:0]  os;
  } hdr_state_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] header_length;
    logic [31:0] mtime;
    logic [7:0]  os_code;
    logic [4:0]  flag_bits;
  } result_t;

  // First optional stage at or after 'from' that the flags enable
  function automatic phase_e next_stage(phase_e from, logic [4:0] flags);
    phase_e ph;
    ph = PH_DONE;
    if (from <= PH_HCRC && (flags & FL_HCRC) != 5'd0) ph = PH_HCRC;
    if (from <= PH_COMMENT && (flags & FL_COMMENT) != 5'd0) ph = PH_COMMENT;
    if (from <= PH_NAME && (flags & FL_NAME) != 5'd0) ph = PH_NAME;
    if (from <= PH_XLEN && (flags & FL_EXTRA) != 5'd0) ph = PH_XLEN;
    return ph;
  endfunction

endpackage

/* rtl/core/gmhp_in_if.sv */
interface gmhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;

  modport source (output valid, data_byte, first, last, input ready);
  modport sink (input valid, data_byte, first, last, output ready);
endinterface

/* rtl/core/gmhp_out_if.sv */
interface gmhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] header_length;
  logic [31:0] mtime;
  logic [7:0]  os_code;
  logic [4:0]  flag_bits;

  modport source (output valid, status, header_length, mtime, os_code, flag_bits,
                  input ready);
  modport sink (input valid, status, header_length, mtime, os_code, flag_bits,
                output ready);
endinterface

/* rtl/core/gmhp_step.sv */
module gmhp_step #(
  parameter int LENGTH_BITS = 16
) (
  input  gmhp_pkg::hdr_state_t   state_i,
  input  logic [LENGTH_BITS-1:0] consumed_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   first_i,
  input  logic                   last_i,
  output gmhp_pkg::hdr_state_t   state_o,
  output logic [LENGTH_BITS-1:0] consumed_o,
  output logic                   res_valid_o,
  output gmhp_pkg::result_t      result_o
);

  localparam int ExtBits = LENGTH_BITS + 16;

  gmhp_pkg::hdr_state_t cur;
  gmhp_pkg::status_e    err_code;
  logic                 err;
  logic                 full;
  logic                 active;
  logic                 complete;
  logic                 emit;
  logic [15:0]          skip_tmp;
  logic [ExtBits-1:0]   len_ext;

  // Next state
  always_comb begin
    cur = state_i;
    consumed_o = consumed_i;
    if (first_i) begin
      cur = '0;
      cur.phase = gmhp_pkg::PH_FIXED;
      consumed_o = '0;
    end
    state_o  = cur;
    err      = 1'b0;
    err_code = gmhp_pkg::ST_OK;
    complete = 1'b0;
    skip_tmp = '0;
    active   = (cur.phase != gmhp_pkg::PH_IDLE) && (cur.phase != gmhp_pkg::PH_DONE);
    full     = active && (consumed_o == {LENGTH_BITS{1'b1}});

    if (active && !full) begin
      consumed_o = consumed_o + LENGTH_BITS'(1);
      unique case (cur.phase)
        gmhp_pkg::PH_FIXED: begin
          if (cur.field_index == gmhp_pkg::IDX_MAGIC0) begin
            if (data_byte_i != gmhp_pkg::MAGIC0) begin
              err = 1'b1;
              err_code = gmhp_pkg::ST_BAD_MAGIC;
            end
          end else if (cur.field_index == gmhp_pkg::IDX_MAGIC1) begin
            if (data_byte_i != gmhp_pkg::MAGIC1) begin
              err = 1'b1;
              err_code = gmhp_pkg::ST_BAD_MAGIC;
            end
          end else if (cur.field_index == gmhp_pkg::IDX_METHOD) begin
            if (data_byte_i != gmhp_pkg::METHOD_DEFLATE) begin
              err = 1'b1;
              err_code = gmhp_pkg::ST_BAD_METH;
            end
          end else if (cur.field_index == gmhp_pkg::IDX_FLAGS) begin
            state_o.flags = data_byte_i[4:0];
            if ((data_byte_i & gmhp_pkg::FL_RESERVED) != 8'd0) begin
              err = 1'b1;
              err_code = gmhp_pkg::ST_RSVD_FLG;
            end
          end else if (cur.field_index >= gmhp_pkg::IDX_MTIME0 &&
                       cur.field_index <= gmhp_pkg::IDX_MTIME3) begin
            state_o.stamp[8*cur.field_index[1:0] +: 8] =
              cur.stamp[8*cur.field_index[1:0] +: 8] | data_byte_i;
          end else if (cur.field_index == gmhp_pkg::IDX_OS) begin
            state_o.os = data_byte_i;
            if (data_byte_i > gmhp_pkg::OS_LAST_KNOWN &&
                data_byte_i != gmhp_pkg::OS_UNKNOWN) begin
              err = 1'b1;
              err_code = gmhp_pkg::ST_BAD_OS;
            end
          end
          if (!err) begin
            if (cur.field_index >= gmhp_pkg::IDX_OS) begin
              state_o.field_index = '0;
              state_o.skip = '0;
              state_o.phase = gmhp_pkg::next_stage(gmhp_pkg::PH_XLEN, state_o.flags);
            end else begin
              state_o.field_index = cur.field_index + 4'd1;
            end
          end
        end
        gmhp_pkg::PH_XLEN: begin
          if (cur.field_index == 4'd0) begin
            state_o.skip = {8'd0, data_byte_i};
            state_o.field_index = 4'd1;
          end else begin
            skip_tmp = cur.skip | {data_byte_i, 8'd0};
            state_o.skip = skip_tmp;
            if (skip_tmp == 16'd0) begin
              state_o.field_index = '0;
              state_o.phase = gmhp_pkg::next_stage(gmhp_pkg::PH_NAME, cur.flags);
            end else begin
              state_o.phase = gmhp_pkg::PH_EXTRA;
            end
          end
        end
        gmhp_pkg::PH_EXTRA: begin
          skip_tmp = cur.skip - 16'd1;
          state_o.skip = skip_tmp;
          if (skip_tmp == 16'd0) begin
            state_o.field_index = '0;
            state_o.phase = gmhp_pkg::next_stage(gmhp_pkg::PH_NAME, cur.flags);
          end
        end
        gmhp_pkg::PH_NAME: begin
          if (data_byte_i == 8'd0) begin
            state_o.field_index = '0;
            state_o.skip = '0;
            state_o.phase = gmhp_pkg::next_stage(gmhp_pkg::PH_COMMENT, cur.flags);
          end
        end
        gmhp_pkg::PH_COMMENT: begin
          if (data_byte_i == 8'd0) begin
            state_o.field_index = '0;
            state_o.skip = '0;
            state_o.phase = gmhp_pkg::next_stage(gmhp_pkg::PH_HCRC, cur.flags);
          end
        end
        gmhp_pkg::PH_HCRC: begin
          if (cur.field_index == 4'd0) begin
            state_o.field_index = 4'd1;
          end else begin
            state_o.field_index = '0;
            state_o.skip = '0;
            state_o.phase = gmhp_pkg::PH_DONE;
          end
        end
        default: begin
          state_o = cur;
        end
      endcase
      complete = !err && (state_o.phase == gmhp_pkg::PH_DONE);
    end

    emit = active && (full || err || complete || last_i);
    if (emit) state_o.phase = gmhp_pkg::PH_DONE;
  end

  // Result
  always_comb begin
    len_ext = {16'd0, consumed_o};
    res_valid_o = emit;
    if (full) begin
      result_o.status = gmhp_pkg::ST_TOO_LONG;
    end else if (err) begin
      result_o.status = err_code;
    end else if (complete) begin
      result_o.status = gmhp_pkg::ST_OK;
    end else begin
      result_o.status = gmhp_pkg::ST_TRUNC;
    end
    result_o.header_length = len_ext[15:0];
    result_o.mtime         = state_o.stamp;
    result_o.os_code       = state_o.os;
    result_o.flag_bits     = state_o.flags;
  end

endmodule

/* rtl/core/gmhp_out_reg.sv */
module gmhp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  gmhp_pkg::result_t result_i,
  input  logic              ready_i,
  output logic              free_o,
  output logic              valid_o,
  output gmhp_pkg::result_t result_o
);

  logic              valid_d, valid_q;
  gmhp_pkg::result_t result_q;

  // Take a new request when empty or whenever the held one leaves this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) valid_d = load_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) result_q <= result_i;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

/* rtl/core/gzip_member_header_parser.sv */
// gzip member header parser.
// Input channel in_i: one request per byte of a candidate stream (data_byte,
// first, last). first restarts the parser on that byte; last marks the final
// byte available, so an unfinished header then reports truncation.
// Output channel out_o: one request per candidate, carrying status,
// header_length (bytes up to the start of the deflate data), mtime, os_code
// and flag_bits. Bytes after a result, or without a first, are dropped.
// Throughput: one byte per cycle unless out_o stalls. The parser state
// registers update on the accepting edge through one level of decode logic,
// so the next byte may follow in the very next cycle.
// Output: the result appears on out_o in the cycle after the deciding byte
// is accepted, from a single output register.
// Reset: asynchronous, active low; the parser goes idle with all captures
// cleared and the output register empty.
// Stall: while a result waits in the output register and out_o.ready is low,
// in_i.ready drops; the parser and the held result keep their values until
// the result is taken, and a new byte is accepted in that same cycle.
module gzip_member_header_parser #(
  parameter int LENGTH_BITS = 16
) (
  input logic            clk_i,
  input logic            rst_ni,
  gmhp_in_if.sink        in_i,
  gmhp_out_if.source     out_o
);

  gmhp_pkg::hdr_state_t   state_d, state_q;
  logic [LENGTH_BITS-1:0] consumed_d, consumed_q;
  logic                   res_valid;
  gmhp_pkg::result_t      res;
  gmhp_pkg::result_t      res_q;
  logic                   free;
  logic                   accept;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  // Decode one byte against the current parser state
  gmhp_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .state_i     (state_q),
    .consumed_i  (consumed_q),
    .data_byte_i (in_i.data_byte),
    .first_i     (in_i.first),
    .last_i      (in_i.last),
    .state_o     (state_d),
    .consumed_o  (consumed_d),
    .res_valid_o (res_valid),
    .result_o    (res)
  );

  // Advance parser state only on an accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '0;
      consumed_q <= '0;
    end else if (accept) begin
      state_q    <= state_d;
      consumed_q <= consumed_d;
    end
  end

  // Hold the result until the receiver takes it
  gmhp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept && res_valid),
    .result_i (res),
    .ready_i  (out_o.ready),
    .free_o   (free),
    .valid_o  (out_o.valid),
    .result_o (res_q)
  );

  assign out_o.status        = res_q.status;
  assign out_o.header_length = res_q.header_length;
  assign out_o.mtime         = res_q.mtime;
  assign out_o.os_code       = res_q.os_code;
  assign out_o.flag_bits     = res_q.flag_bits;

endmodule

/* tb/gmhp_tb_pkg.sv */
package gmhp_tb_pkg;
  import gmhp_pkg::*;

  // Byte-level parser model plus the queue of header results it predicts.
  class header_tracker #(int LENGTH_BITS = 16);
    phase_e          ph;
    logic [3:0]      idx;
    logic [4:0]      flg;
    logic [15:0]     skip;
    logic [31:0]     stamp;
    logic [7:0]      os;
    longint unsigned consumed;

    result_t         pending_headers[$];
    int unsigned     mismatches;
    int unsigned     parsed_bytes;

    function new();
      restart();
      mismatches   = 0;
      parsed_bytes = 0;
    endfunction

    function void restart();
      ph       = PH_IDLE;
      idx      = '0;
      flg      = '0;
      skip     = '0;
      stamp    = '0;
      os       = '0;
      consumed = 0;
    endfunction

    // Move to the first optional field at or after 'from' that the flags ask
    // for; report whether the header is already complete.
    function bit enter_stage(phase_e from);
      idx  = '0;
      skip = '0;
      if (from <= PH_XLEN && (flg & FL_EXTRA) != 5'd0) ph = PH_XLEN;
      else if (from <= PH_NAME && (flg & FL_NAME) != 5'd0) ph = PH_NAME;
      else if (from <= PH_COMMENT && (flg & FL_COMMENT) != 5'd0) ph = PH_COMMENT;
      else if (from <= PH_HCRC && (flg & FL_HCRC) != 5'd0) ph = PH_HCRC;
      else ph = PH_DONE;
      return ph == PH_DONE;
    endfunction

    function void note_request(logic [7:0] b, bit is_first, bit is_last);
      result_t r;
      status_e st;
      bit      decided;
      bit      done;
      decided = 1'b0;
      done    = 1'b0;
      st      = ST_OK;
      if (is_first) begin
        restart();
        ph = PH_FIXED;
      end
      // drop bytes outside a candidate
      if (ph == PH_IDLE || ph == PH_DONE) return;
      parsed_bytes++;

      if (consumed >= ((64'd1 << LENGTH_BITS) - 64'd1)) begin
        decided = 1'b1;
        st      = ST_TOO_LONG;
      end else begin
        consumed++;
        case (ph)
          PH_FIXED: begin
            case (idx)
              IDX_MAGIC0: if (b != MAGIC0) begin decided = 1'b1; st = ST_BAD_MAGIC; end
              IDX_MAGIC1: if (b != MAGIC1) begin decided = 1'b1; st = ST_BAD_MAGIC; end
              IDX_METHOD: if (b != METHOD_DEFLATE) begin
                decided = 1'b1;
                st      = ST_BAD_METH;
              end
              IDX_FLAGS: begin
                flg = b[4:0];
                if ((b & FL_RESERVED) != 8'd0) begin decided = 1'b1; st = ST_RSVD_FLG; end
              end
              IDX_OS: begin
                os = b;
                if (b > OS_LAST_KNOWN && b != OS_UNKNOWN) begin
                  decided = 1'b1;
                  st      = ST_BAD_OS;
                end
              end
              default: begin
                if (idx >= IDX_MTIME0 && idx <= IDX_MTIME3)
                  stamp |= {24'd0, b} << (8 * (idx - IDX_MTIME0));
              end
            endcase
            if (!decided) begin
              if (idx == IDX_OS) done = enter_stage(PH_XLEN);
              else idx++;
            end
          end
          PH_XLEN: begin
            if (idx == 4'd0) begin
              skip = {8'd0, b};
              idx  = 4'd1;
            end else begin
              skip[15:8] = b;
              if (skip == 16'd0) done = enter_stage(PH_NAME);
              else ph = PH_EXTRA;
            end
          end
          PH_EXTRA: begin
            skip--;
            if (skip == 16'd0) done = enter_stage(PH_NAME);
          end
          PH_NAME:    if (b == 8'd0) done = enter_stage(PH_COMMENT);
          PH_COMMENT: if (b == 8'd0) done = enter_stage(PH_HCRC);
          default: begin
            if (idx == 4'd0) idx = 4'd1;
            else done = enter_stage(PH_DONE);
          end
        endcase
        if (!decided && done) begin
          decided = 1'b1;
          st      = ST_OK;
        end else if (!decided && is_last) begin
          decided = 1'b1;
          st      = ST_TRUNC;
        end
      end

      if (!decided) return;
      r.status        = st;
      r.header_length = 16'(consumed);
      r.mtime         = stamp;
      r.os_code       = os;
      r.flag_bits     = flg;
      pending_headers = {pending_headers, r};
      ph = PH_DONE;
    endfunction

    task flag_mismatch(string what);
      // keep the log short if the block is badly broken
      if (mismatches < 100) $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_headers.size() == 0) begin
        flag_mismatch($sformatf("result with no header pending, status %0d", got.status));
        return;
      end
      want = pending_headers.pop_front();
      if (got.status !== want.status)
        flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.header_length !== want.header_length)
        flag_mismatch($sformatf("header_length got %0d want %0d",
                                got.header_length, want.header_length));
      if (got.mtime !== want.mtime)
        flag_mismatch($sformatf("mtime got %h want %h", got.mtime, want.mtime));
      if (got.os_code !== want.os_code)
        flag_mismatch($sformatf("os_code got %0d want %0d", got.os_code, want.os_code));
      if (got.flag_bits !== want.flag_bits)
        flag_mismatch($sformatf("flag_bits got %h want %h", got.flag_bits, want.flag_bits));
    endtask
  endclass

endpackage

/* tb/gzip_member_header_parser_test.sv */
module gzip_member_header_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gmhp_pkg::*;
  import gmhp_tb_pkg::*;

  localparam int          LEN_BITS        = 16;
  localparam int unsigned RANDOM_BYTES    = 1150;
  localparam int unsigned HOLD_OFF_CYCLES = 250;
  // the limit sits well above the slowest legal run
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_CHOKED, SINK_PERIODIC} sink_style_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gmhp_in_if  in_if ();
  gmhp_out_if out_if ();

  gzip_member_header_parser #(
    .LENGTH_BITS (LEN_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  header_tracker #(LEN_BITS) headers;

  // sender state: bytes left in the current burst
  int unsigned burst_left = 0;
  // raised once by the stimulus; the sink then holds off on its own count
  bit          hold_off_req = 1'b0;
  // bytes of the candidate being built
  logic [7:0]  cand_q[$];
  int unsigned cycle_count = 0;

  always #2 clk_i = ~clk_i;

  // Give up if the run hangs; a hang counts as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sample both channels at the rising edge. Check the result first: a byte
  // accepted on this edge can only produce a result on a later one.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.status        = status_e'(out_if.status);
        got.header_length = out_if.header_length;
        got.mtime         = out_if.mtime;
        got.os_code       = out_if.os_code;
        got.flag_bits     = out_if.flag_bits;
        headers.check_result(got);
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
        headers.note_request(in_if.data_byte, in_if.first, in_if.last);
    end
  end

  // Result sink: switch among stall styles at random intervals, and take
  // one long hold-off when asked so the parser fills and stalls its input.
  initial begin
    int unsigned span;
    int unsigned hold_left;
    int unsigned tick;
    bit          hold_taken;
    sink_style_e style;
    span         = 0;
    hold_left    = 0;
    tick         = 0;
    hold_taken   = 1'b0;
    style        = SINK_OPEN;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      tick++;
      if (span == 0) begin
        style = sink_style_e'($urandom_range(0, 3));
        span  = $urandom_range(16, 160);
      end
      span--;
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (style)
          SINK_OPEN:   out_if.ready <= 1'b1;
          SINK_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          SINK_CHOKED: out_if.ready <= ($urandom_range(0, 5) == 0);
          default:     out_if.ready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // Offer one byte request and hold it until accepted. Bursts of random
  // length are separated by random gaps; a zero gap keeps valid high across
  // back-to-back requests.
  task automatic push_byte(input logic [7:0] b, input bit is_first, input bit is_last);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 2);
        2:       gap = $urandom_range(1, 6);
        default: gap = $urandom_range(3, 12);
      endcase
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.first     <= is_first;
    in_if.last      <= is_last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  // Send the first 'count' bytes of the candidate; flag the final one as last
  // when asked.
  task automatic send_candidate(input bit with_last, input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      push_byte(cand_q[i], i == 0, with_last && i == count - 1);
  endtask

  // Add one byte to the end of the candidate being built.
  function automatic void append_byte(input logic [7:0] b);
    cand_q = {cand_q, b};
  endfunction

  function automatic logic [7:0] pick_known_os();
    int unsigned v;
    v = $urandom_range(0, 14);
    return (v == 14) ? OS_UNKNOWN : 8'(v);
  endfunction

  // Append the fixed ten-byte header with random timestamp and extra flags.
  task automatic put_fixed(input logic [4:0] flags);
    append_byte(MAGIC0);
    append_byte(MAGIC1);
    append_byte(METHOD_DEFLATE);
    append_byte({3'b000, flags});
    repeat (4) append_byte(8'($urandom));
    append_byte(8'($urandom));
    append_byte(pick_known_os());
  endtask

  // Append the optional fields that the flags ask for, with random content.
  task automatic put_optional(input logic [4:0] flags);
    int unsigned xlen;
    int unsigned n;
    if ((flags & FL_EXTRA) != 5'd0) begin
      // mostly short extra fields, empty ones included; now and then a long one
      xlen = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
      append_byte(xlen[7:0]);
      append_byte(xlen[15:8]);
      repeat (xlen) append_byte(8'($urandom));
    end
    if ((flags & FL_NAME) != 5'd0) begin
      n = $urandom_range(0, 6);
      repeat (n) append_byte(8'($urandom_range(1, 255)));
      append_byte(8'd0);
    end
    if ((flags & FL_COMMENT) != 5'd0) begin
      n = $urandom_range(0, 6);
      repeat (n) append_byte(8'($urandom_range(1, 255)));
      append_byte(8'd0);
    end
    if ((flags & FL_HCRC) != 5'd0) begin
      append_byte(8'($urandom));
      append_byte(8'($urandom));
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned kind;
    int unsigned cut;
    int unsigned n;
    logic [7:0]  v;
    logic [4:0]  flags;

    headers         = new();
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'd0;
    in_if.first     = 1'b0;
    in_if.last      = 1'b0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- Directed: one request sequence per status and special case ---

    // stray byte while idle, with last set: dropped, no result
    push_byte(8'h5a, 1'b0, 1'b1);
    // bad first magic byte together with last: the error wins over truncation
    cand_q = {8'h00};
    send_candidate(1'b1, cand_q.size());
    // bad second magic byte
    cand_q = {MAGIC0, 8'h00};
    send_candidate(1'b0, cand_q.size());
    // wrong compression method
    cand_q = {MAGIC0, MAGIC1, 8'h00};
    send_candidate(1'b0, cand_q.size());
    // every reserved flag bit set
    cand_q = {MAGIC0, MAGIC1, METHOD_DEFLATE, 8'hff};
    send_candidate(1'b0, cand_q.size());
    // all legal flags, timestamp all ones, first OS code past the known range
    cand_q = {MAGIC0, MAGIC1, METHOD_DEFLATE, 8'h1f, 8'hff, 8'hff, 8'hff, 8'hff,
              8'h00, 8'd14};
    send_candidate(1'b0, cand_q.size());
    // candidate ends after one byte: truncated
    cand_q = {MAGIC0};
    send_candidate(1'b1, cand_q.size());

    // --- Random candidates: mostly well formed, the rest broken or noise ---
    base = headers.parsed_bytes;
    while (headers.parsed_bytes - base < RANDOM_BYTES) begin
      // part way in, make the sink hold off while requests keep coming
      if (!hold_off_req && headers.parsed_bytes - base > 300) hold_off_req = 1'b1;

      kind  = $urandom_range(0, 99);
      flags = 5'($urandom);
      cand_q.delete();
      put_fixed(flags);
      put_optional(flags);

      if (kind < 60) begin
        // complete header, maybe with last on its final byte, then deflate
        // bytes that the parser must drop
        send_candidate($urandom_range(0, 3) == 0, cand_q.size());
        n = $urandom_range(0, 4);
        for (int unsigned i = 0; i < n; i++)
          push_byte(8'($urandom), 1'b0, (i == n - 1) && $urandom_range(0, 1));
      end else if (kind < 75) begin
        // cut short; without last the next first restarts mid-header
        cut = $urandom_range(1, cand_q.size() - 1);
        send_candidate($urandom_range(0, 9) < 7, cut);
      end else if (kind < 90) begin
        // corrupt one checked field of the fixed header
        case ($urandom_range(0, 4))
          0: begin
            do v = 8'($urandom); while (v == MAGIC0);
            cand_q[IDX_MAGIC0] = v;
          end
          1: begin
            do v = 8'($urandom); while (v == MAGIC1);
            cand_q[IDX_MAGIC1] = v;
          end
          2: begin
            do v = 8'($urandom); while (v == METHOD_DEFLATE);
            cand_q[IDX_METHOD] = v;
          end
          3: cand_q[IDX_FLAGS] = cand_q[IDX_FLAGS] | (8'($urandom_range(1, 7)) << 5);
          default: cand_q[IDX_OS] = 8'($urandom_range(14, 254));
        endcase
        send_candidate($urandom_range(0, 3) == 0, cand_q.size());
      end else begin
        // noise: random bytes with random first and last marks
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end
    end

    // drop valid after the final request
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // wait for the outstanding results, then keep watching for strays
    while (headers.pending_headers.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (headers.mismatches == 0 && headers.pending_headers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gmhp_pkg.sv
rtl/core/gmhp_in_if.sv
rtl/core/gmhp_out_if.sv
rtl/core/gmhp_step.sv
rtl/core/gmhp_out_reg.sv
rtl/core/gzip_member_header_parser.sv
tb/gmhp_tb_pkg.sv
tb/gzip_member_header_parser_test.sv
